### design/ppc_pkg.sv
// Shared types, codes and fixed-point helpers for the polar pose controller.
package ppc_pkg;

  typedef logic signed [67:0] wide_t;

  localparam int STEP_W = 6;
  localparam int SQRT_STEPS = 32;

  localparam wide_t WIDE_MAX32 = 68'sd2147483647;
  localparam wide_t WIDE_MIN32 = -68'sd2147483648;

  localparam logic signed [32:0] W_ODOM = 33'sd966367642;
  localparam logic signed [32:0] W_LIDAR = 33'sd107374182;
  localparam logic signed [25:0] DEG_TO_RAD = 26'sd18740330;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] NORM_LIMIT = 36'sd536870912;

  localparam logic [2:0] REG_GAIN_RHO = 3'd0;
  localparam logic [2:0] REG_GAIN_ALPHA = 3'd1;
  localparam logic [2:0] REG_GAIN_BETA = 3'd2;
  localparam logic [2:0] REG_LINEAR_CAP = 3'd3;
  localparam logic [2:0] REG_ANGULAR_CAP = 3'd4;
  localparam logic [2:0] REG_GOAL_OFFSET_X = 3'd5;
  localparam logic [2:0] REG_DRIVE_LENGTH = 3'd6;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE = 5'd0;
  localparam op_t OP_LOAD = 5'd1;
  localparam op_t OP_ROT = 5'd2;
  localparam op_t OP_MPX = 5'd3;
  localparam op_t OP_MPY = 5'd4;
  localparam op_t OP_REF = 5'd5;
  localparam op_t OP_DIFF = 5'd6;
  localparam op_t OP_FX0 = 5'd7;
  localparam op_t OP_FX1 = 5'd8;
  localparam op_t OP_FY0 = 5'd9;
  localparam op_t OP_FY1 = 5'd10;
  localparam op_t OP_SQ0 = 5'd11;
  localparam op_t OP_SQ1 = 5'd12;
  localparam op_t OP_SQ2 = 5'd13;
  localparam op_t OP_SQRT = 5'd14;
  localparam op_t OP_AINIT = 5'd15;
  localparam op_t OP_NORM = 5'd16;
  localparam op_t OP_VEC = 5'd17;
  localparam op_t OP_GV = 5'd18;
  localparam op_t OP_GW = 5'd19;
  localparam op_t OP_FIN = 5'd20;
  localparam op_t OP_FDONE = 5'd21;

  typedef struct packed {
    op_t op;
    logic [STEP_W-1:0] step;
  } ppc_cmd_t;

  typedef struct packed {
    logic reached;
    logic stop;
    logic norm_more;
    logic vec_zero;
    logic out_free;
  } ppc_sts_t;

  function automatic logic [29:0] atan_lut(logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837829;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic wide_t rnd_shr(wide_t v, int unsigned s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    logic signed [31:0] r;
    if (v > WIDE_MAX32) begin
      r = 32'sh7FFFFFFF;
    end else if (v < WIDE_MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/ppc_ctrl.sv
// Sequencer that steps the datapath through one item.
module ppc_ctrl import ppc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ppc_sts_t sts,
  output ppc_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ROT = 5'd1;
  localparam logic [4:0] S_MPX = 5'd2;
  localparam logic [4:0] S_MPY = 5'd3;
  localparam logic [4:0] S_REF = 5'd4;
  localparam logic [4:0] S_DIFF = 5'd5;
  localparam logic [4:0] S_FX0 = 5'd6;
  localparam logic [4:0] S_FX1 = 5'd7;
  localparam logic [4:0] S_FY0 = 5'd8;
  localparam logic [4:0] S_FY1 = 5'd9;
  localparam logic [4:0] S_SQ0 = 5'd10;
  localparam logic [4:0] S_SQ1 = 5'd11;
  localparam logic [4:0] S_SQ2 = 5'd12;
  localparam logic [4:0] S_SQRT = 5'd13;
  localparam logic [4:0] S_AINIT = 5'd14;
  localparam logic [4:0] S_NORM = 5'd15;
  localparam logic [4:0] S_VEC = 5'd16;
  localparam logic [4:0] S_GV = 5'd17;
  localparam logic [4:0] S_GW = 5'd18;
  localparam logic [4:0] S_FIN = 5'd19;
  localparam logic [4:0] S_FDONE = 5'd20;

  localparam logic [STEP_W-1:0] LAST_CORDIC = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_SQRT = STEP_W'(SQRT_STEPS - 1);

  logic [4:0] state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign cmd.step = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          cnt_nxt = '0;
          state_nxt = sts.reached ? S_FDONE : S_ROT;
        end
      end
      S_ROT: begin
        cmd.op = OP_ROT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CORDIC) begin
          cnt_nxt = '0;
          state_nxt = S_MPX;
        end
      end
      S_MPX: begin
        cmd.op = OP_MPX;
        state_nxt = S_MPY;
      end
      S_MPY: begin
        cmd.op = OP_MPY;
        state_nxt = S_REF;
      end
      S_REF: begin
        cmd.op = OP_REF;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op = OP_DIFF;
        state_nxt = S_FX0;
      end
      S_FX0: begin
        cmd.op = OP_FX0;
        state_nxt = sts.stop ? S_FDONE : S_FX1;
      end
      S_FX1: begin
        cmd.op = OP_FX1;
        state_nxt = S_FY0;
      end
      S_FY0: begin
        cmd.op = OP_FY0;
        state_nxt = S_FY1;
      end
      S_FY1: begin
        cmd.op = OP_FY1;
        state_nxt = S_SQ0;
      end
      S_SQ0: begin
        cmd.op = OP_SQ0;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.op = OP_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.op = OP_SQ2;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SQRT) begin
          cnt_nxt = '0;
          state_nxt = S_AINIT;
        end
      end
      S_AINIT: begin
        cmd.op = OP_AINIT;
        state_nxt = sts.vec_zero ? S_GV : S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (!sts.norm_more) begin
          cnt_nxt = '0;
          state_nxt = S_VEC;
        end
      end
      S_VEC: begin
        cmd.op = OP_VEC;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CORDIC) begin
          cnt_nxt = '0;
          state_nxt = S_GV;
        end
      end
      S_GV: begin
        cmd.op = OP_GV;
        state_nxt = S_GW;
      end
      S_GW: begin
        cmd.op = OP_GW;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FDONE: begin
        cmd.op = OP_FDONE;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT || state_r == S_VEC) |-> (cnt_r <= LAST_CORDIC))
    else $error("cordic step count out of range");

  a_sqrt_to_atan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && cnt_r == LAST_SQRT) |=> (state_r == S_AINIT))
    else $error("square root did not hand over to atan2");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_ROT || state_r == S_FDONE))
    else $error("accepted item did not start");

endmodule

### design/ppc_dp.sv
// Datapath: config registers, CORDIC unit, multiplier, square root, output register.
module ppc_dp import ppc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppc_cmd_t           cmd,
  output ppc_sts_t           sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_odom_pos_x,
  input  logic signed [31:0] in_odom_pos_y,
  input  logic [8:0]         in_scan_angle_deg,
  input  logic [30:0]        in_scan_range,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_linear_speed,
  output logic signed [31:0] out_angular_speed,
  output logic               out_reached
);

  logic signed [31:0] gain_rho_r, gain_alpha_r, gain_beta_r;
  logic signed [31:0] linear_cap_r, angular_cap_r, goal_offset_x_r, drive_length_r;

  logic signed [31:0] ox_r, oy_r;
  logic [30:0] rng_r;
  logic neg_r;
  logic signed [35:0] cx_r, cy_r, cz_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] px_r, py_r;
  logic have_ref_r, done_r;
  logic signed [31:0] ref_ox_r, ref_oy_r, ref_px_r, ref_py_r;
  logic signed [32:0] odx_r, ody_r, lx_r, ly_r;
  logic signed [35:0] acc_r;
  logic signed [31:0] dx_r, dy_r;
  logic [63:0] sq_r, res_r;
  logic signed [32:0] alpha_r;
  logic signed [31:0] v_r;
  logic out_valid_r;
  logic signed [31:0] out_lin_r, out_ang_r;
  logic out_reached_r;

  logic signed [10:0] ang_a, ang_b, ang_c, ang_d;
  logic ang_neg;
  logic signed [36:0] ang_z;
  logic signed [35:0] xs, ys, at, cos_v, sin_v;
  logic signed [32:0] mul_a, mul_b;
  logic mul_en;
  wide_t prod_w, r30, rfr;
  logic signed [31:0] py_now;
  logic [30:0] rho;
  logic [5:0] sq_shift;
  logic [63:0] sq_bit, sq_try;
  logic sq_ge;
  logic out_free;

  function automatic logic signed [31:0] cap_sat(wide_t v, logic signed [31:0] cap);
    logic signed [31:0] r;
    if (v > wide_t'(cap)) begin
      r = cap;
    end else begin
      r = sat32(v);
    end
    return r;
  endfunction

  always_comb begin
    ang_a = $signed({2'b00, in_scan_angle_deg});
    ang_b = (ang_a >= 11'sd360) ? ang_a - 11'sd360 : ang_a;
    ang_c = (ang_b > 11'sd180) ? ang_b - 11'sd360 : ang_b;
    ang_neg = 1'b0;
    ang_d = ang_c;
    if (ang_c > 11'sd90) begin
      ang_d = ang_c - 11'sd180;
      ang_neg = 1'b1;
    end else if (ang_c < -11'sd90) begin
      ang_d = ang_c + 11'sd180;
      ang_neg = 1'b1;
    end
    ang_z = 37'(ang_d) * 37'(DEG_TO_RAD);
  end

  assign xs = cx_r >>> cmd.step[4:0];
  assign ys = cy_r >>> cmd.step[4:0];
  assign at = $signed({6'b0, atan_lut(cmd.step[4:0])});
  assign cos_v = neg_r ? -cx_r : cx_r;
  assign sin_v = neg_r ? -cy_r : cy_r;

  assign prod_w = wide_t'(prod_r);
  assign r30 = rnd_shr(prod_w, 30);
  assign rfr = rnd_shr(prod_w, FRAC_BITS);
  assign py_now = sat32(r30);

  assign rho = (res_r > 64'd2147483647) ? 31'h7FFFFFFF : res_r[30:0];

  assign sq_shift = 6'd62 - {cmd.step[4:0], 1'b0};
  assign sq_bit = 64'd1 << sq_shift;
  assign sq_try = res_r + sq_bit;
  assign sq_ge = (sq_r >= sq_try);

  assign out_free = !out_valid_r || !out_stall;

  assign sts.reached = done_r;
  assign sts.stop = (34'(lx_r) >= (34'(ref_px_r) + 34'(drive_length_r)));
  assign sts.norm_more = (cx_r < NORM_LIMIT) && (cy_r < NORM_LIMIT) && (cy_r > -NORM_LIMIT);
  assign sts.vec_zero = (dx_r == '0) && (dy_r == '0);
  assign sts.out_free = out_free;

  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MPX: begin
        mul_a = $signed({2'b00, rng_r});
        mul_b = cos_v[32:0];
      end
      OP_MPY: begin
        mul_a = $signed({2'b00, rng_r});
        mul_b = sin_v[32:0];
      end
      OP_FX0: begin
        mul_a = odx_r;
        mul_b = W_ODOM;
      end
      OP_FX1: begin
        mul_a = lx_r;
        mul_b = W_LIDAR;
      end
      OP_FY0: begin
        mul_a = ody_r;
        mul_b = W_ODOM;
      end
      OP_FY1: begin
        mul_a = ly_r;
        mul_b = W_LIDAR;
      end
      OP_SQ0: begin
        mul_a = 33'(dx_r);
        mul_b = 33'(dx_r);
      end
      OP_SQ1: begin
        mul_a = 33'(dy_r);
        mul_b = 33'(dy_r);
      end
      OP_GV: begin
        mul_a = 33'(gain_rho_r);
        mul_b = $signed({2'b00, rho});
      end
      OP_GW: begin
        mul_a = 33'(gain_alpha_r) - 33'(gain_beta_r);
        mul_b = alpha_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        ox_r <= in_odom_pos_x;
        oy_r <= in_odom_pos_y;
        rng_r <= in_scan_range;
        neg_r <= ang_neg;
        cx_r <= CORDIC_GAIN;
        cy_r <= '0;
        cz_r <= ang_z[35:0];
      end
      OP_ROT: begin
        if (!cz_r[35]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      OP_MPY: begin
        px_r <= sat32(r30);
      end
      OP_REF: begin
        py_r <= py_now;
        if (!have_ref_r) begin
          ref_ox_r <= ox_r;
          ref_oy_r <= oy_r;
          ref_px_r <= px_r;
          ref_py_r <= py_now;
        end
      end
      OP_DIFF: begin
        odx_r <= 33'(ox_r) - 33'(ref_ox_r);
        ody_r <= 33'(oy_r) - 33'(ref_oy_r);
        lx_r <= 33'(ref_px_r) - 33'(px_r);
        ly_r <= 33'(ref_py_r) - 33'(py_r);
      end
      OP_FX1: begin
        acc_r <= 36'(wide_t'(goal_offset_x_r) - r30);
      end
      OP_FY0: begin
        dx_r <= sat32(wide_t'(acc_r) + r30);
      end
      OP_FY1: begin
        acc_r <= 36'(-r30);
      end
      OP_SQ0: begin
        dy_r <= sat32(wide_t'(acc_r) + r30);
      end
      OP_SQ1: begin
        sq_r <= prod_r[63:0];
      end
      OP_SQ2: begin
        sq_r <= sq_r + prod_r[63:0];
        res_r <= '0;
      end
      OP_SQRT: begin
        if (sq_ge) begin
          sq_r <= sq_r - sq_try;
          res_r <= (res_r >> 1) + sq_bit;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      OP_AINIT: begin
        if (dx_r[31]) begin
          cx_r <= -36'(dx_r);
          cy_r <= -36'(dy_r);
          cz_r <= dy_r[31] ? -PI_Q30 : PI_Q30;
        end else begin
          cx_r <= 36'(dx_r);
          cy_r <= 36'(dy_r);
          cz_r <= '0;
        end
      end
      OP_NORM: begin
        if (sts.norm_more) begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      OP_VEC: begin
        if (!cy_r[35]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end
      end
      OP_GV: begin
        alpha_r <= 33'(rnd_shr(wide_t'(cz_r), 30 - FRAC_BITS));
      end
      OP_GW: begin
        v_r <= cap_sat(rfr, linear_cap_r);
      end
      OP_FIN: begin
        if (out_free) begin
          out_lin_r <= v_r;
          out_ang_r <= cap_sat(rfr, angular_cap_r);
          out_reached_r <= 1'b0;
        end
      end
      OP_FDONE: begin
        if (out_free) begin
          out_lin_r <= '0;
          out_ang_r <= '0;
          out_reached_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r <= 1'b0;
      done_r <= 1'b0;
      out_valid_r <= 1'b0;
      gain_rho_r <= 32'sd13107;
      gain_alpha_r <= -32'sd32768;
      gain_beta_r <= 32'sd13107;
      linear_cap_r <= 32'sd3932;
      angular_cap_r <= 32'sd4588;
      goal_offset_x_r <= 32'sd68092;
      drive_length_r <= 32'sd327680;
    end else begin
      if (cmd.op == OP_REF) begin
        have_ref_r <= 1'b1;
      end
      if (cmd.op == OP_FX0 && sts.stop) begin
        done_r <= 1'b1;
      end
      if ((cmd.op == OP_FIN || cmd.op == OP_FDONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_RHO: gain_rho_r <= cfg_data;
          REG_GAIN_ALPHA: gain_alpha_r <= cfg_data;
          REG_GAIN_BETA: gain_beta_r <= cfg_data;
          REG_LINEAR_CAP: linear_cap_r <= cfg_data;
          REG_ANGULAR_CAP: angular_cap_r <= cfg_data;
          REG_GOAL_OFFSET_X: goal_offset_x_r <= cfg_data;
          REG_DRIVE_LENGTH: drive_length_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_linear_speed = out_lin_r;
  assign out_angular_speed = out_ang_r;
  assign out_reached = out_reached_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done flag dropped");

  a_ref_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_ref_r |=> have_ref_r)
    else $error("reference flag dropped");

  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reached_r) |-> (out_lin_r == '0 && out_ang_r == '0))
    else $error("nonzero speed on a reached item");

endmodule

### design/polar_pose_controller_core.sv
// Top level of the polar pose controller: sequencer plus datapath.
// Each item carries odometry x/y, a lidar angle and range and yields one speed
// command. One item is in work at a time. Each item makes two CORDIC passes
// through one shared rotator, normalizing ahead of the atan2 stage, and uses
// the 32-step square root and the single shared multiplier. Once the drive
// distance is reached, every later item skips straight to a zero-speed answer
// with the reached flag set. The input is stalled while an item is in work; a
// finished result waits in the output register, and the next item cannot
// finish until that register is free.
module polar_pose_controller_core import ppc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_odom_pos_x,
  input  logic signed [31:0] in_odom_pos_y,
  input  logic [8:0]         in_scan_angle_deg,
  input  logic [30:0]        in_scan_range,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_linear_speed,
  output logic signed [31:0] out_angular_speed,
  output logic               out_reached
);

  ppc_cmd_t cmd;
  ppc_sts_t sts;

  ppc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  ppc_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_odom_pos_x(in_odom_pos_x),
    .in_odom_pos_y(in_odom_pos_y),
    .in_scan_angle_deg(in_scan_angle_deg),
    .in_scan_range(in_scan_range),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_linear_speed(out_linear_speed),
    .out_angular_speed(out_angular_speed),
    .out_reached(out_reached)
  );

endmodule
